// ===== sv/iprfw_pkg.sv =====
package iprfw_pkg;

	localparam int MAX_FIELDS_DEF = 64;

	localparam logic [15:0] PAD_ELEMENT = 16'd210;
	localparam logic [31:0] PEN_REVERSE = 32'd29305;
	localparam logic [15:0] VAR_LENGTH  = 16'hFFFF;
	localparam logic [7:0]  LONG_PREFIX = 8'hFF;
	localparam logic [15:0] OFFSET_MAX  = 16'hFFFF;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_BYTE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TRUNC     = 2'd1,
		ST_BEYOND    = 2'd2,
		ST_BAD_ENTRY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CFG_FIELDS_IN_USE   = 3'd0,
		CFG_SHOW_PADDING    = 3'd1,
		CFG_SKIP_UNKNOWN    = 3'd2,
		CFG_SKIP_REVERSE    = 3'd3,
		CFG_FIND_MODE       = 3'd4,
		CFG_FIND_ELEMENT    = 3'd5,
		CFG_FIND_ENTERPRISE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [6:0]  fields_in_use;
		logic        show_padding;
		logic        skip_unknown;
		logic        skip_reverse;
		logic        find_mode;
		logic [15:0] find_element;
		logic [31:0] find_enterprise;
	} cfg_t;

	typedef struct packed {
		logic        command;
		logic [5:0]  entry_index;
		logic [15:0] entry_element;
		logic [31:0] entry_enterprise;
		logic [15:0] entry_length;
		logic        entry_known;
		logic        entry_reverse;
		logic [7:0]  data_byte;
		logic        last_byte;
	} in_item_t;

	typedef struct packed {
		logic        reverse;
		logic        known;
		logic [15:0] length;
		logic [31:0] enterprise;
		logic [15:0] element;
	} tmpl_entry_t;

	typedef struct packed {
		logic        en;
		logic [5:0]  index;
		tmpl_entry_t data;
	} tmpl_wr_t;

	typedef struct packed {
		status_t     status;
		logic        record_done;
		logic [31:0] field_enterprise;
		logic [15:0] field_element;
		logic [15:0] data_size;
		logic [15:0] data_offset;
		logic [5:0]  field_position;
		logic        field_valid;
	} result_t;

endpackage

// ===== sv/ipfix_record_field_walker.sv =====
// IPFIX data record walker.
// The s_ side takes one beat per item: s_tuser = 1 carries a record byte, 0 loads one
// template entry into the template memory. s_tlast marks the last byte of a record.
// The m_ side gives zero or one result per item: a field report (m_tuser = 1) on the
// first data byte of a field (on the length byte of an empty one), a bad-entry status
// for a rejected load, and a record close (m_tlast = 1) with its status on the last byte.
// The cfg_ channel writes the filter and template-size registers; write it only while
// no record is in flight.
// Throughput: one item per cycle while s_tready is high. The template memory is read at
// the position the walk will stand on next, so each byte finds its entry already registered.
// Output: each result is registered in the output buffer before it reaches m_tvalid.
// Stall: results go to a two-beat output buffer; s_tready drops only when both beats
// are held, and rises again as soon as m_tready takes one.
// Reset: the walk returns to the first field at offset 0; configuration and valid flags clear.
// Template contents are undefined until loaded; no clearing pass runs.
module ipfix_record_field_walker #(
	parameter int MAX_FIELDS = iprfw_pkg::MAX_FIELDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index, entry_element, entry_enterprise, entry_length, entry_known,
	// entry_reverse, data_byte
	input  logic [79:0] s_tdata,
	// command
	input  logic        s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// field_position, data_offset, data_size, field_element, field_enterprise, status
	output logic [87:0] m_tdata,
	// field_valid
	output logic        m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import iprfw_pkg::*;

	localparam int AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

	cfg_t        cfg_q;
	in_item_t    item;
	tmpl_entry_t tmpl_rd;
	tmpl_wr_t    tmpl_wr;
	logic [AW-1:0] rd_addr;
	logic        accept, res_valid, buf_ready;
	result_t     res, out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FIELDS_IN_USE:   cfg_q.fields_in_use   <= cfg_data[6:0];
				CFG_SHOW_PADDING:    cfg_q.show_padding    <= cfg_data[0];
				CFG_SKIP_UNKNOWN:    cfg_q.skip_unknown    <= cfg_data[0];
				CFG_SKIP_REVERSE:    cfg_q.skip_reverse    <= cfg_data[0];
				CFG_FIND_MODE:       cfg_q.find_mode       <= cfg_data[0];
				CFG_FIND_ELEMENT:    cfg_q.find_element    <= cfg_data[15:0];
				CFG_FIND_ENTERPRISE: cfg_q.find_enterprise <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item.command          = s_tuser;
	assign item.entry_index      = s_tdata[5:0];
	assign item.entry_element    = s_tdata[21:6];
	assign item.entry_enterprise = s_tdata[53:22];
	assign item.entry_length     = s_tdata[69:54];
	assign item.entry_known      = s_tdata[70];
	assign item.entry_reverse    = s_tdata[71];
	assign item.data_byte        = s_tdata[79:72];
	assign item.last_byte        = s_tlast;

	assign s_tready = buf_ready;
	assign accept   = s_tvalid && buf_ready;

	iprfw_tmpl_mem #(
		.DEPTH (MAX_FIELDS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr      (tmpl_wr),
		.rd_addr (rd_addr),
		.rd_data (tmpl_rd)
	);

	iprfw_walk #(
		.MAX_FIELDS (MAX_FIELDS),
		.AW         (AW)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.item      (item),
		.tmpl_rd   (tmpl_rd),
		.tmpl_wr   (tmpl_wr),
		.rd_addr   (rd_addr),
		.res_valid (res_valid),
		.res       (res)
	);

	iprfw_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.ready     (buf_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {out_res.status, out_res.field_enterprise, out_res.field_element,
		out_res.data_size, out_res.data_offset, out_res.field_position};
	assign m_tuser = out_res.field_valid;
	assign m_tlast = out_res.record_done;

endmodule

// ===== sv/iprfw_tmpl_mem.sv =====
module iprfw_tmpl_mem #(
	parameter int DEPTH = iprfw_pkg::MAX_FIELDS_DEF,
	parameter int AW    = 6
) (
	input  logic                   clk,
	input  iprfw_pkg::tmpl_wr_t    wr,
	input  logic [AW-1:0]          rd_addr,
	output iprfw_pkg::tmpl_entry_t rd_data
);
	import iprfw_pkg::*;

	tmpl_entry_t mem [DEPTH];
	logic [AW-1:0] wr_addr;

	assign wr_addr = AW'(wr.index);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
	end

	// forward a same-cycle write to the entry being read
	always_ff @(posedge clk) begin
		if (wr.en && wr_addr == rd_addr) begin
			rd_data <= wr.data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/iprfw_walk.sv =====
module iprfw_walk #(
	parameter int MAX_FIELDS = iprfw_pkg::MAX_FIELDS_DEF,
	parameter int AW         = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iprfw_pkg::cfg_t        cfg,
	input  logic                   accept,
	input  iprfw_pkg::in_item_t    item,
	input  iprfw_pkg::tmpl_entry_t tmpl_rd,
	output iprfw_pkg::tmpl_wr_t    tmpl_wr,
	output logic [AW-1:0]          rd_addr,
	output logic                   res_valid,
	output iprfw_pkg::result_t     res
);
	import iprfw_pkg::*;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_SIZE_HI = 2'd1,
		PH_SIZE_LO = 2'd2,
		PH_DATA    = 2'd3
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [6:0]  pos_q, n_pos, pos_inc;
	logic [15:0] offset_q, n_offset, offset_inc;
	logic [15:0] rem_q, n_rem, rem_dec, long_size;
	logic [7:0]  hi_q, n_hi;
	logic        shown, beyond, passes, idx_ok;
	logic [15:0] rep_offset, rep_size;

	function automatic logic past_end(input logic [6:0] pos, input logic [6:0] in_use);
		past_end = (32'(pos) >= 32'(MAX_FIELDS)) || (pos >= in_use);
	endfunction

	assign pos_inc    = pos_q + 7'd1;
	assign offset_inc = (offset_q == OFFSET_MAX) ? offset_q : offset_q + 16'd1;
	assign long_size  = {hi_q, item.data_byte};
	assign idx_ok     = 32'(item.entry_index) < 32'(MAX_FIELDS);

	always_comb begin
		if (cfg.find_mode) begin
			passes = (tmpl_rd.element == cfg.find_element)
				&& (tmpl_rd.enterprise == cfg.find_enterprise);
		end else begin
			passes = 1'b1;
			if (!cfg.show_padding && tmpl_rd.element == PAD_ELEMENT
				&& (tmpl_rd.enterprise == '0 || tmpl_rd.enterprise == PEN_REVERSE)) begin
				passes = 1'b0;
			end
			if (cfg.skip_unknown && !tmpl_rd.known) begin
				passes = 1'b0;
			end
			if (cfg.skip_reverse && tmpl_rd.reverse) begin
				passes = 1'b0;
			end
		end
	end

	always_comb begin
		n_pos      = pos_q;
		n_phase    = phase_q;
		n_offset   = offset_q;
		n_rem      = rem_q;
		n_hi       = hi_q;
		shown      = 1'b0;
		beyond     = 1'b0;
		rep_offset = offset_q;
		rep_size   = '0;
		rem_dec    = '0;
		res_valid  = 1'b0;
		res        = '0;
		tmpl_wr.en    = 1'b0;
		tmpl_wr.index = item.entry_index;
		tmpl_wr.data  = '{reverse: item.entry_reverse, known: item.entry_known,
			length: item.entry_length, enterprise: item.entry_enterprise,
			element: item.entry_element};

		if (accept && item.command == CMD_LOAD) begin
			if (item.entry_length == '0 || !idx_ok) begin
				res_valid  = 1'b1;
				res.status = ST_BAD_ENTRY;
			end else begin
				tmpl_wr.en = 1'b1;
			end
		end else if (accept) begin
			unique case (phase_q)
				PH_START: begin
					if (rem_q != '0) begin
						shown    = passes;
						rep_size = rem_q;
						rem_dec  = rem_q - 16'd1;
						if (rem_dec == '0) begin
							n_pos = pos_inc;
							n_rem = '0;
						end else begin
							n_rem   = rem_dec;
							n_phase = PH_DATA;
						end
					end else if (past_end(pos_q, cfg.fields_in_use)) begin
						beyond = 1'b1;
					end else if (tmpl_rd.length != VAR_LENGTH) begin
						shown    = passes;
						rep_size = tmpl_rd.length;
						if (tmpl_rd.length <= 16'd1) begin
							n_pos = pos_inc;
						end else begin
							n_rem   = tmpl_rd.length - 16'd1;
							n_phase = PH_DATA;
						end
					end else if (item.data_byte == LONG_PREFIX) begin
						n_phase = PH_SIZE_HI;
					end else if (item.data_byte == '0) begin
						shown      = passes;
						rep_offset = offset_inc;
						n_pos      = pos_inc;
					end else begin
						n_rem = 16'(item.data_byte);
					end
				end
				PH_SIZE_HI: begin
					n_hi    = item.data_byte;
					n_phase = PH_SIZE_LO;
				end
				PH_SIZE_LO: begin
					n_phase = PH_START;
					if (long_size == '0) begin
						shown      = passes;
						rep_offset = offset_inc;
						n_pos      = pos_inc;
						n_rem      = '0;
					end else begin
						n_rem = long_size;
					end
				end
				PH_DATA: begin
					rem_dec = (rem_q != '0) ? rem_q - 16'd1 : '0;
					if (rem_dec == '0) begin
						n_pos   = pos_inc;
						n_phase = PH_START;
						n_rem   = '0;
					end else begin
						n_rem = rem_dec;
					end
				end
			endcase

			n_offset = offset_inc;

			if (shown) begin
				res_valid            = 1'b1;
				res.field_valid      = 1'b1;
				res.field_position   = 6'(pos_q);
				res.data_offset      = rep_offset;
				res.data_size        = rep_size;
				res.field_element    = tmpl_rd.element;
				res.field_enterprise = tmpl_rd.enterprise;
			end

			if (item.last_byte) begin
				res_valid       = 1'b1;
				res.record_done = 1'b1;
				if (beyond) begin
					res.status = ST_BEYOND;
				end else if (n_phase != PH_START || n_rem != '0
					|| !past_end(n_pos, cfg.fields_in_use)) begin
					res.status = ST_TRUNC;
				end else begin
					res.status = ST_OK;
				end
				n_pos    = '0;
				n_phase  = PH_START;
				n_offset = '0;
				n_rem    = '0;
				n_hi     = '0;
			end
		end
	end

	assign rd_addr = AW'(n_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_START;
			offset_q <= '0;
			rem_q    <= '0;
			hi_q     <= '0;
		end else begin
			pos_q    <= n_pos;
			phase_q  <= n_phase;
			offset_q <= n_offset;
			rem_q    <= n_rem;
			hi_q     <= n_hi;
		end
	end

endmodule

// ===== sv/iprfw_out_buf.sv =====
module iprfw_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  iprfw_pkg::result_t push_data,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_ready,
	output iprfw_pkg::result_t out_data
);
	import iprfw_pkg::*;

	logic    out_valid_q, skid_valid_q, take;
	result_t out_data_q, skid_data_q;

	assign take      = out_valid_q && out_ready;
	assign ready     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (push) begin
					skid_data_q <= push_data;
				end
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

endmodule
